FILE: src/mcf_crc_pkg.sv
// Shared types, constants and CRC byte update for the motor command framer.
`default_nettype none

package mcf_crc_pkg;

  localparam int unsigned PAY_BYTES = 10;
  localparam int unsigned PAY_W     = 8 * PAY_BYTES;
  localparam int unsigned FRAME_LEN = 12;
  localparam int unsigned IDX_W     = 4;

  localparam logic [15:0]      CRC_INIT = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY = 16'hA001;
  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(PAY_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic [15:0] speed;
    logic        turn_direction;
    logic [15:0] angle;
    logic [15:0] run_time;
    logic [15:0] turn_count;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_byte;
  } res_t;

  // one pipeline slot: payload bytes still to send (next byte on top) and CRC so far
  typedef struct packed {
    logic             vld;
    logic [PAY_W-1:0] pay;
    logic [15:0]      crc;
  } pipe_t;

  // reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/mcf_crc_stage.sv
// One framer pipeline stage: folds the top payload byte into the CRC and shifts it out.
`default_nettype none

module mcf_crc_stage
  import mcf_crc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  pipe_t stg_in,
  output pipe_t stg_out
);

  pipe_t stg_r;
  pipe_t stg_nxt;

  always_comb begin
    stg_nxt.vld = stg_in.vld;
    stg_nxt.pay = {stg_in.pay[PAY_W-9:0], 8'h00};
    stg_nxt.crc = crc_add_byte(stg_in.crc, stg_in.pay[PAY_W-1 -: 8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else begin
      stg_r.vld <= stg_nxt.vld;
    end
    stg_r.pay <= stg_nxt.pay;
    stg_r.crc <= stg_nxt.crc;
  end

  assign stg_out = stg_r;

endmodule

`default_nettype wire

FILE: src/motor_command_frame_crc16.sv
// Top level: motor command framer emitting a 12-byte frame with CRC-16/MODBUS trailer.
// Output: byte 0 of a frame reaches the result ports through the entry slot and the output
//   register after start is taken, then one byte per cycle through byte 11 (CRC low byte).
// Overlap: busy holds a new command back while any byte stage is valid; the next start is
//   taken at the edge that registers the CRC low byte of the previous frame.
// Reset: synchronous, active low; clears all valid bits and the result strobe.
// The receiver cannot stall, so once a command is taken its 12 words come out back to back.
`default_nettype none

module motor_command_frame_crc16
  import mcf_crc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  cmd_t in_cmd,
  output logic out_strobe,
  output res_t out_res
);

  // stg[s] holds the command while byte s is due; stg[10] holds the finished CRC
  pipe_t stg [PAY_BYTES+1];

  pipe_t stg0_r;
  pipe_t stg0_nxt;
  logic  accept;

  // last slot only carries the CRC low byte
  logic       lo_vld_r;
  logic [7:0] lo_byte_r;

  logic out_strobe_r;
  logic out_strobe_nxt;
  res_t out_res_r;
  res_t out_res_nxt;

  logic [PAY_BYTES:0] stg_vld;

  // a new command may enter only when no frame is still ahead of its CRC low byte
  always_comb begin
    for (int s = 0; s <= PAY_BYTES; s++) begin
      stg_vld[s] = stg[s].vld;
    end
  end

  assign busy   = |stg_vld;
  assign accept = start && !busy;

  // entry slot: the direction bit goes out as the 16-bit word 0x0000/0x0001
  always_comb begin
    stg0_nxt.vld = accept;
    stg0_nxt.pay = {in_cmd.speed, 15'h0000, in_cmd.turn_direction,
                    in_cmd.angle, in_cmd.run_time, in_cmd.turn_count};
    stg0_nxt.crc = CRC_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg0_r.vld <= 1'b0;
    end else begin
      stg0_r.vld <= stg0_nxt.vld;
    end
    if (accept) begin
      stg0_r.pay <= stg0_nxt.pay;
      stg0_r.crc <= stg0_nxt.crc;
    end
  end

  assign stg[0] = stg0_r;

  // ten byte stages, each folds one payload byte into the running CRC
  for (genvar g = 0; g < PAY_BYTES; g++) begin : g_stage
    mcf_crc_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .stg_in  (stg[g]),
      .stg_out (stg[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_vld_r <= 1'b0;
    end else begin
      lo_vld_r <= stg[PAY_BYTES].vld;
    end
    lo_byte_r <= stg[PAY_BYTES].crc[7:0];
  end

  // At most one slot is valid at a time (busy holds a new command back until the last frame
  // has left the byte stages), so the result word is a plain select of whichever slot is live.
  always_comb begin
    out_strobe_nxt         = 1'b0;
    out_res_nxt.frame_byte = 8'h00;
    out_res_nxt.byte_index = '0;
    out_res_nxt.last_byte  = 1'b0;
    for (int s = 0; s < PAY_BYTES; s++) begin
      if (stg[s].vld) begin
        out_strobe_nxt         = 1'b1;
        out_res_nxt.frame_byte = stg[s].pay[PAY_W-1 -: 8];
        out_res_nxt.byte_index = IDX_W'(s);
      end
    end
    if (stg[PAY_BYTES].vld) begin
      out_strobe_nxt         = 1'b1;
      out_res_nxt.frame_byte = stg[PAY_BYTES].crc[15:8];   // CRC goes high byte first
      out_res_nxt.byte_index = IDX_CRC_HI;
    end
    if (lo_vld_r) begin
      out_strobe_nxt         = 1'b1;
      out_res_nxt.frame_byte = lo_byte_r;
      out_res_nxt.byte_index = IDX_LAST;
      out_res_nxt.last_byte  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

`default_nettype wire

FILE: src/mcf_crc_chk.sv
// Port-level checker for the motor command framer, bound to the top level.
`default_nettype none

module mcf_crc_chk
  import mcf_crc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe,
  input wire res_t out_res
);

  // a taken command shows byte 0 once it has passed the entry slot and the output register
  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 (out_strobe && out_res.byte_index == '0))
    else $error("frame did not start two cycles after accept");

  // bytes of a frame come out back to back in index order
  a_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.byte_index != IDX_LAST |=>
      out_strobe && out_res.byte_index == $past(out_res.byte_index) + 1'b1)
    else $error("frame bytes not contiguous");

  // last flag marks exactly the final byte
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_res.last_byte == (out_res.byte_index == IDX_LAST)))
    else $error("last flag mismatch");

  // no new command can be taken while a frame still has bytes before its CRC low byte
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.byte_index != IDX_LAST && out_res.byte_index != IDX_CRC_HI
      |-> busy)
    else $error("busy dropped mid-frame");

endmodule

bind motor_command_frame_crc16 mcf_crc_chk u_chk (.*);

`default_nettype wire

FILE: test/motor_frame_checker.sv
// Checker for the motor command framer: predicts each 12-word frame and compares it.
module motor_frame_checker
  import mcf_crc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  cmd_t in_cmd,
  input  logic out_strobe,
  input  res_t out_res,
  output int   mismatches,
  output int   words_due,
  output int   frames_taken,
  output int   words_checked
);

  localparam logic [15:0] MODBUS_SEED = 16'hFFFF;
  localparam logic [15:0] MODBUS_POLY = 16'hA001;
  localparam int          FRAME_WORDS = 12;
  localparam int          REPORT_MAX  = 10;

  res_t frame_words_pending[$];

  // CRC-16/MODBUS over the ten payload bytes, one bit at a time, LSB of each byte first
  function automatic logic [15:0] modbus_crc(input logic [79:0] payload);
    logic [15:0] crc;
    logic [7:0]  b;
    logic        fb;
    crc = MODBUS_SEED;
    for (int i = 0; i < 10; i++) begin
      b = payload[79 - 8 * i -: 8];
      for (int k = 0; k < 8; k++) begin
        fb  = crc[0] ^ b[k];
        crc = {1'b0, crc[15:1]};
        if (fb) begin
          crc = crc ^ MODBUS_POLY;
        end
      end
    end
    return crc;
  endfunction

  // queue the twelve words one command should produce
  function automatic void predict_frame(input cmd_t c);
    logic [95:0] frame;
    logic [79:0] payload;
    res_t        w;
    payload = {c.speed, 15'd0, c.turn_direction, c.angle, c.run_time, c.turn_count};
    frame   = {payload, modbus_crc(payload)};
    for (int i = 0; i < FRAME_WORDS; i++) begin
      w.frame_byte = frame[95 - 8 * i -: 8];
      w.byte_index = i[3:0];
      w.last_byte  = (i == FRAME_WORDS - 1);
      frame_words_pending.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      mismatches    = 0;
      frames_taken  = 0;
      words_checked = 0;
      frame_words_pending.delete();
    end else begin
      if (start && !busy) begin
        predict_frame(in_cmd);
        frames_taken = frames_taken + 1;
      end
      if (out_strobe) begin
        if (frame_words_pending.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch: unexpected word byte=%h index=%0d last=%b",
                     out_res.frame_byte, out_res.byte_index, out_res.last_byte);
          end
        end else begin
          want = frame_words_pending.pop_front();
          words_checked = words_checked + 1;
          if (out_res.frame_byte !== want.frame_byte ||
              out_res.byte_index !== want.byte_index ||
              out_res.last_byte  !== want.last_byte) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_MAX) begin
              $display("mismatch: byte exp %h got %h, index exp %0d got %0d, last exp %b got %b",
                       want.frame_byte, out_res.frame_byte, want.byte_index,
                       out_res.byte_index, want.last_byte, out_res.last_byte);
            end
          end
        end
      end
    end
    words_due <= frame_words_pending.size();
  end

endmodule

FILE: test/motor_command_frame_crc16_test.sv
// Testbench top for the motor command framer: stimulus, watchdog and verdict.
module motor_command_frame_crc16_test;
  import mcf_crc_pkg::*;

  // a command taking longer than this with no word moving means the block hung
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_CMDS  = 100;
  localparam int IDLE_PCT     = 23;
  localparam int TAIL_CYCLES  = 20;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;
  logic start  = 1'b0;
  cmd_t in_cmd = '0;
  logic busy;
  logic out_strobe;
  res_t out_res;

  int mismatches;
  int words_due;
  int frames_taken;
  int words_checked;
  int quiet_cycles = 0;
  bit steady       = 1'b0;   // set to suppress idle gaps on the sender side

  initial begin
    forever #6 clk = ~clk;
  end

  motor_command_frame_crc16 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  motor_frame_checker frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .out_strobe    (out_strobe),
    .out_res       (out_res),
    .mismatches    (mismatches),
    .words_due     (words_due),
    .frames_taken  (frames_taken),
    .words_checked (words_checked)
  );

  // Watchdog: any accepted command or any result word resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles with no word moving, %0d words still due",
               QUIET_LIMIT, words_due);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cmd_t make_cmd(input logic [15:0] spd, input logic dir,
                                    input logic [15:0] ang, input logic [15:0] dur,
                                    input logic [15:0] turns);
    cmd_t c;
    c.speed          = spd;
    c.turn_direction = dir;
    c.angle          = ang;
    c.run_time       = dur;
    c.turn_count     = turns;
    return c;
  endfunction

  // Half of the words uniform, the rest corner values so bytes at and above
  // 0x80 and all-zero / all-one words keep turning up.
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    case ($urandom_range(7))
      0:       w = 16'h0000;
      1:       w = 16'hFFFF;
      2:       w = 16'h8000 | 16'($urandom_range(16'h7FFF));
      3:       w = 16'($urandom_range(255)) | 16'h0080;
      default: w = 16'($urandom_range(16'hFFFF));
    endcase
    return w;
  endfunction

  // Present one command and hold it until the block takes it. The random gap
  // lengths land the next start on every phase of the frame in flight.
  task automatic issue_command(input cmd_t c);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start  <= 1'b1;
    in_cmd <= c;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int   directed_cmds;
    cmd_t c;
    directed_cmds = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, bytes with the top bit set, alternating bits,
    // and the same command twice in a row (framing holds no state)
    issue_command(make_cmd(16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    issue_command(make_cmd(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    issue_command(make_cmd(16'h8000, 1'b1, 16'h8000, 16'h8000, 16'h8000));
    issue_command(make_cmd(16'h7FFF, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    issue_command(make_cmd(16'h0080, 1'b1, 16'h0080, 16'h0080, 16'h0080));
    issue_command(make_cmd(16'h00FF, 1'b0, 16'hFF00, 16'h00FF, 16'hFF00));
    issue_command(make_cmd(16'hAAAA, 1'b0, 16'h5555, 16'hAAAA, 16'h5555));
    issue_command(make_cmd(16'h5555, 1'b1, 16'hAAAA, 16'h5555, 16'hAAAA));
    issue_command(make_cmd(16'h0001, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    issue_command(make_cmd(16'h0000, 1'b0, 16'h0000, 16'h0000, 16'hFFFF));
    issue_command(make_cmd(16'h1234, 1'b1, 16'h5678, 16'h9ABC, 16'hDEF0));
    issue_command(make_cmd(16'h1234, 1'b1, 16'h5678, 16'h9ABC, 16'hDEF0));
    issue_command(make_cmd(16'hFF80, 1'b0, 16'h80FF, 16'hC3A5, 16'h0FF0));
    directed_cmds = 13;

    // random; a long middle stretch runs back to back with no sender idling
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      steady = (n >= 40 && n < 75);
      c = make_cmd(pick_word(), 1'($urandom_range(1)), pick_word(), pick_word(),
                   pick_word());
      issue_command(c);
    end
    start <= 1'b0;

    // drain: wait for every predicted word, then watch a while for strays
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d commands (%0d directed, %0d random), %0d frame words checked",
             frames_taken, directed_cmds, RANDOM_CMDS, words_checked);
    $display("mismatching words: %0d, words still due: %0d", mismatches, words_due);
    if (mismatches == 0 && words_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
